// ----- hdl/sensor_frame_crc_check_convert_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sensor frame checker/converter
// ---------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC_CHECK_CONVERT_TOP_MACROS_SVH
`define SENSOR_FRAME_CRC_CHECK_CONVERT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, idle during reset.
`define SFCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfcc assertion failed");

// Next-cycle implication, sampled on clk_i, idle during reset.
`define SFCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfcc assertion failed");

`endif

// ----- hdl/sfcc_pkg.sv -----
// ---------------------------------------------------------------------------
// sfcc_pkg
// Shared codes, constants and types of the sensor frame checker/converter.
// ---------------------------------------------------------------------------
package sfcc_pkg;

  // command kinds (any other code behaves as a measurement)
  localparam logic [1:0] KIND_MEAS       = 2'd0;
  localparam logic [1:0] KIND_SERIAL     = 2'd1;
  localparam logic [1:0] KIND_SOFT_RESET = 2'd2;

  // CRC-8, MSB first
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // conversion constants
  localparam int TEMP_SCALE  = 17500;
  localparam int TEMP_OFFSET = 4500 * 65535;
  localparam int HUM_SCALE   = 1000;
  localparam int FULL_SCALE  = 65535;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  // result beat, packed from lowest bit up (struct lists MSB first)
  typedef struct packed {
    logic [3:0]         pad;
    logic               humidity_ok;
    logic [9:0]         humidity;
    logic               temperature_ok;
    logic signed [14:0] temperature;
    logic [31:0]        serial_id;
    logic               status;
  } result_t;

endpackage

// ----- hdl/sfcc_crc8_check.sv -----
// ---------------------------------------------------------------------------
// sfcc_crc8_check
// Checks one sensor word: two data bytes plus CRC-8 byte, remainder zero.
// ---------------------------------------------------------------------------
module sfcc_crc8_check (
  input  logic [7:0] hi_i,
  input  logic [7:0] lo_i,
  input  logic [7:0] chk_i,
  output logic       ok_o
);
  import sfcc_pkg::*;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  logic [7:0] crc_hi, crc_lo, crc_chk;

  assign crc_hi  = crc_byte(CRC_INIT, hi_i);
  assign crc_lo  = crc_byte(crc_hi, lo_i);
  assign crc_chk = crc_byte(crc_lo, chk_i);
  assign ok_o    = (crc_chk == 8'h00);

endmodule

// ----- hdl/sensor_frame_crc_check_convert_top.sv -----
// ---------------------------------------------------------------------------
// sensor_frame_crc_check_convert_top
// Sensor readout frame CRC check and temperature/humidity/serial conversion.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: one beat per 6-byte readout frame. tdata carries byte_0
//   (bits 7:0) up to byte_5 (bits 47:40); tuser carries the command kind
//   (measurement, serial read, soft reset).
//   Output stream: one beat per frame with status, serial number,
//   temperature (centidegrees), humidity (permille) and their valid flags.
//   Depth: three register stages; a taken beat passes the stage 1, 2 and 3
//   registers in turn before it raises m_axis_tvalid_o.
//   Throughput: one frame per cycle unless stalled, frames fully independent.
//   Pipeline: stage 1 runs both CRC checks and the two scale multiplies,
//   stage 2 removes the temperature offset and splits the /65535 quotient,
//   stage 3 applies the quotient correction and assembles the result.
//   Stall: each stage advances when the stage after it is empty or moving,
//   so a stalled receiver fills the three stages and then drops
//   s_axis_tready_o; nothing is lost or repeated.
//   Reset: rst_ni clears all stage valid bits; the pipeline comes up empty.
// ---------------------------------------------------------------------------
module sensor_frame_crc_check_convert_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // byte_0[7:0], byte_1[15:8], byte_2[23:16], byte_3[31:24], byte_4[39:32], byte_5[47:40]
  input  logic [sfcc_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // kind[1:0]
  input  logic [1:0]                       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // status[0], serial_id[32:1], temperature[47:33], temperature_ok[48],
  // humidity[58:49], humidity_ok[59], zero pad[63:60]
  output logic [sfcc_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);
  import sfcc_pkg::*;

  // stage handshake: advance when the next stage is free or draining
  logic adv1, adv2, adv3;
  logic v1_q, v2_q, v3_q;

  assign adv3 = !v3_q || m_axis_tready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign s_axis_tready_o = adv1;

  // ---------------- stage 1: CRC + multiply ----------------
  logic [7:0] b0, b1, b2, b3, b4, b5;
  assign b0 = s_axis_tdata_i[7:0];
  assign b1 = s_axis_tdata_i[15:8];
  assign b2 = s_axis_tdata_i[23:16];
  assign b3 = s_axis_tdata_i[31:24];
  assign b4 = s_axis_tdata_i[39:32];
  assign b5 = s_axis_tdata_i[47:40];

  logic ok_a, ok_b;

  sfcc_crc8_check u_crc_a (.hi_i(b0), .lo_i(b1), .chk_i(b2), .ok_o(ok_a));
  sfcc_crc8_check u_crc_b (.hi_i(b3), .lo_i(b4), .chk_i(b5), .ok_o(ok_b));

  logic [1:0]  kind1_q;
  logic        ok_a1_q, ok_b1_q;
  logic [31:0] ser1_q;
  logic [30:0] tprod1_q;   // raw * 17500
  logic [25:0] hprod1_q;   // raw * 1000

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      kind1_q  <= s_axis_tuser_i;
      ok_a1_q  <= ok_a;
      ok_b1_q  <= ok_b;
      ser1_q   <= {b0, b1, b3, b4};
      tprod1_q <= 31'({b0, b1}) * 31'(TEMP_SCALE);
      hprod1_q <= 26'({b3, b4}) * 26'(HUM_SCALE);
    end
  end

  // ---------------- stage 2: offset, quotient split ----------------
  // x / 65535: q = x >> 16, remainder estimate r = x[15:0] + q; one fix-up later
  logic signed [31:0] tnum;
  logic [31:0]        tmag_full;
  logic               tneg;
  logic [29:0]        tmag;

  assign tnum      = $signed({1'b0, tprod1_q}) - 32'(TEMP_OFFSET);
  assign tneg      = tnum[31];
  assign tmag_full = tneg ? 32'(-tnum) : 32'(tnum);
  assign tmag      = tmag_full[29:0];

  logic [1:0]  kind2_q;
  logic        ok_a2_q, ok_b2_q, tneg2_q;
  logic [31:0] ser2_q;
  logic [13:0] tq2_q;
  logic [16:0] tr2_q;
  logic [9:0]  hq2_q;
  logic [16:0] hr2_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      kind2_q <= kind1_q;
      ok_a2_q <= ok_a1_q;
      ok_b2_q <= ok_b1_q;
      ser2_q  <= ser1_q;
      tneg2_q <= tneg;
      tq2_q   <= tmag[29:16];
      tr2_q   <= {1'b0, tmag[15:0]} + {3'b000, tmag[29:16]};
      hq2_q   <= hprod1_q[25:16];
      hr2_q   <= {1'b0, hprod1_q[15:0]} + {7'b0, hprod1_q[25:16]};
    end
  end

  // ---------------- stage 3: correction + result assembly ----------------
  logic [13:0]        tq_fix;
  logic signed [14:0] temp_val;
  logic [9:0]         hq_fix;
  logic               is_meas, is_serial;
  result_t            res_d, res_q;

  assign tq_fix   = tq2_q + ((tr2_q >= 17'(FULL_SCALE)) ? 14'd1 : 14'd0);
  assign temp_val = tneg2_q ? -$signed({1'b0, tq_fix}) : $signed({1'b0, tq_fix});
  assign hq_fix   = hq2_q + ((hr2_q >= 17'(FULL_SCALE)) ? 10'd1 : 10'd0);

  assign is_serial = (kind2_q == KIND_SERIAL);
  assign is_meas   = (kind2_q != KIND_SERIAL) && (kind2_q != KIND_SOFT_RESET);

  always_comb begin
    res_d                = '0;
    res_d.status         = !(ok_a2_q && ok_b2_q);
    if (is_serial) begin
      res_d.serial_id = res_d.status ? 32'hFFFF_FFFF : ser2_q;
    end
    res_d.temperature_ok = is_meas && ok_a2_q;
    res_d.humidity_ok    = is_meas && ok_b2_q;
    if (res_d.temperature_ok) begin
      res_d.temperature = temp_val;
    end
    if (res_d.humidity_ok) begin
      res_d.humidity = hq_fix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      res_q <= res_d;
    end
  end

  // valid bits follow the data through the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = res_q;

endmodule

// ----- hdl/sfcc_checker.sv -----
// ---------------------------------------------------------------------------
// sfcc_checker
// Port-level checks of the sensor frame checker/converter, bound to the top.
// ---------------------------------------------------------------------------
`include "sensor_frame_crc_check_convert_top_macros.svh"

module sfcc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [sfcc_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);
  import sfcc_pkg::*;

  result_t res;
  logic    out_stall;
  logic    meas_out;

  assign res       = m_axis_tdata_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign meas_out  = m_axis_tvalid_o && (res.temperature_ok || res.humidity_ok);

  // a pending result beat holds while stalled
  `SFCC_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // a draining output always leaves room at the input
  `SFCC_ASSERT_NOW(a_ready_through, m_axis_tready_i, s_axis_tready_o)

  // a temperature whose flag is low reads as zero
  `SFCC_ASSERT_NOW(a_temp_zero, m_axis_tvalid_o && !res.temperature_ok, res.temperature == 15'sd0)

  // humidity stays within full scale
  `SFCC_ASSERT_NOW(a_hum_range, m_axis_tvalid_o && res.humidity_ok, res.humidity <= 10'd1000)

  // a measurement never carries a serial number
  `SFCC_ASSERT_NOW(a_meas_no_serial, meas_out, res.serial_id == 32'd0)

endmodule

bind sensor_frame_crc_check_convert_top sfcc_checker u_sfcc_checker (.*);

// ----- dv/tb.sv -----
// ---------------------------------------------------------------------------
// tb: testbench for sensor_frame_crc_check_convert_top
// Streams readout frames (measurement, serial read, soft reset and the spare
// kind code) into the block, mostly with correct CRC bytes and the rest with
// corrupted check bytes or plain noise. Each result beat is checked field by
// field against a scoreboard that predicts the CRC status and the
// temperature, humidity and serial conversions. Source and sink throttle in
// three phases; one pause lets the pipeline drain completely.
// ---------------------------------------------------------------------------
module tb;
  import sfcc_pkg::*;

  // The fourth kind code has no name in the package; it behaves as a measurement.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int RAND_FRAMES  = 850;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS  = 10;

  // -------------------------------------------------------------------------
  // Scoreboard: predicted result beats in arrival order
  // -------------------------------------------------------------------------
  class readout_scoreboard;
    result_t predicted_q[$];
    int      errors;
    int      beats_seen;
    int      n_meas;
    int      n_serial;
    int      n_reset;
    int      n_bad_crc;

    // Check byte of one word: remainder is zero over hi, lo, check
    // exactly when check equals the CRC over hi and lo.
    static function logic [7:0] word_crc(logic [7:0] hi, logic [7:0] lo);
      logic [7:0] crc;
      logic [7:0] data [2];
      data[0] = hi;
      data[1] = lo;
      crc = CRC_INIT;
      for (int i = 0; i < 2; i++) begin
        crc = crc ^ data[i];
        for (int b = 0; b < 8; b++) begin
          crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
        end
      end
      return crc;
    endfunction

    function result_t predict_readout(logic [1:0] kind, logic [47:0] frame);
      result_t    r;
      logic [7:0] b [6];
      logic       a_good;
      logic       b_good;
      logic [15:0] raw_t;
      logic [15:0] raw_h;
      longint     num;
      for (int i = 0; i < 6; i++) b[i] = frame[8*i +: 8];
      a_good = (word_crc(b[0], b[1]) == b[2]);
      b_good = (word_crc(b[3], b[4]) == b[5]);
      raw_t  = {b[0], b[1]};
      raw_h  = {b[3], b[4]};
      r = '0;
      r.status = !(a_good && b_good);
      if (kind == KIND_SERIAL) begin
        r.serial_id = r.status ? 32'hFFFF_FFFF : {b[0], b[1], b[3], b[4]};
      end else if (kind != KIND_SOFT_RESET) begin
        if (a_good) begin
          // signed division truncates toward zero
          num = longint'(raw_t) * 17500 - longint'(4500) * 65535;
          r.temperature    = 15'(num / 65535);
          r.temperature_ok = 1'b1;
        end
        if (b_good) begin
          r.humidity    = 10'((int'(raw_h) * 1000) / 65535);
          r.humidity_ok = 1'b1;
        end
      end
      return r;
    endfunction

    function void note_frame(logic [1:0] kind, logic [47:0] frame);
      result_t r;
      r = predict_readout(kind, frame);
      predicted_q.push_back(r);
      if (kind == KIND_SERIAL) n_serial++;
      else if (kind == KIND_SOFT_RESET) n_reset++;
      else n_meas++;
      if (r.status) n_bad_crc++;
    endfunction

    function void check_beat(logic [OUT_DATA_W-1:0] beat);
      result_t got;
      result_t want;
      got = result_t'(beat);
      beats_seen++;
      if (predicted_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch #%0d: result beat %h with no frame outstanding", errors, beat);
        return;
      end
      want = predicted_q.pop_front();
      if (got.status         !== want.status         ||
          got.serial_id      !== want.serial_id      ||
          got.temperature    !== want.temperature    ||
          got.temperature_ok !== want.temperature_ok ||
          got.humidity       !== want.humidity       ||
          got.humidity_ok    !== want.humidity_ok    ||
          got.pad            !== want.pad) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch #%0d exp: st=%b sn=%h t=%0d tok=%b h=%0d hok=%b pad=%h",
                   errors, want.status, want.serial_id, want.temperature,
                   want.temperature_ok, want.humidity, want.humidity_ok, want.pad);
          $display("             got: st=%b sn=%h t=%0d tok=%b h=%0d hok=%b pad=%h",
                   got.status, got.serial_id, got.temperature,
                   got.temperature_ok, got.humidity, got.humidity_ok, got.pad);
        end
      end
    endfunction

    function int pending();
      return predicted_q.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT hookup
  // -------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  src_valid;
  logic                  src_ready;
  logic [IN_DATA_W-1:0]  src_frame;   // byte_0 in [7:0] ... byte_5 in [47:40]
  logic [1:0]            src_kind;    // kind[1:0]
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  logic [OUT_DATA_W-1:0] res_beat;    // status, serial, temp, temp_ok, hum, hum_ok

  int snd_idle_pct;
  int rcv_idle_pct;

  readout_scoreboard sb;

  sensor_frame_crc_check_convert_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (src_valid),
    .s_axis_tready_o (src_ready),
    .s_axis_tdata_i  (src_frame),
    .s_axis_tuser_i  (src_kind),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_beat)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sink throttle: new ready decision every cycle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Inputs only move at rising edges, so the falling edge shows what the
  // next rising edge will accept.
  always @(negedge clk_i) begin
    if (rst_ni && res_valid && res_ready) sb.check_beat(res_beat);
  end

  // -------------------------------------------------------------------------
  // Source side
  // -------------------------------------------------------------------------
  // Called just after a rising edge; returns just after the edge that took the beat.
  task automatic send_frame(logic [1:0] kind, logic [47:0] frame);
    while ($urandom_range(99) < snd_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk_i);
    end
    src_valid <= 1'b1;
    src_frame <= frame;
    src_kind  <= kind;
    do @(negedge clk_i); while (!src_ready);
    sb.note_frame(kind, frame);
    @(posedge clk_i);
  endtask

  // Two words with their check bytes, each check byte optionally xor-damaged.
  function automatic logic [47:0] make_frame(logic [15:0] raw_a, logic [15:0] raw_b,
                                             logic [7:0] err_a, logic [7:0] err_b);
    logic [7:0] crc_a;
    logic [7:0] crc_b;
    crc_a = readout_scoreboard::word_crc(raw_a[15:8], raw_a[7:0]) ^ err_a;
    crc_b = readout_scoreboard::word_crc(raw_b[15:8], raw_b[7:0]) ^ err_b;
    return {crc_b, raw_b[7:0], raw_b[15:8], crc_a, raw_a[7:0], raw_a[15:8]};
  endfunction

  function automatic logic [15:0] pick_raw();
    int p;
    p = $urandom_range(19);
    if (p == 0) return 16'h0000;
    if (p == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic send_random_frame();
    int          kp;
    int          pick;
    logic [1:0]  kind;
    logic [7:0]  err_a;
    logic [7:0]  err_b;
    logic [63:0] noise;
    kp   = $urandom_range(9);
    kind = (kp < 4) ? KIND_MEAS : (kp < 7) ? KIND_SERIAL :
           (kp < 9) ? KIND_SOFT_RESET : KIND_SPARE;
    pick  = $urandom_range(99);
    err_a = '0;
    err_b = '0;
    if (pick >= 90) begin
      // raw noise: CRC almost always fails
      noise = {$urandom, $urandom};
      send_frame(kind, noise[47:0]);
    end else begin
      if (pick >= 75) begin
        case ($urandom_range(2))
          0: err_a = 8'($urandom_range(255, 1));
          1: err_b = 8'($urandom_range(255, 1));
          default: begin
            err_a = 8'($urandom_range(255, 1));
            err_b = 8'($urandom_range(255, 1));
          end
        endcase
      end
      send_frame(kind, make_frame(pick_raw(), pick_raw(), err_a, err_b));
    end
  endtask

  task automatic wait_drained();
    src_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Directed frames: value extremes, the temperature sign change, every kind
  // and every combination of failing words.
  task automatic run_directed();
    send_frame(KIND_MEAS,       make_frame(16'h0000, 16'h0000, 8'h00, 8'h00));
    send_frame(KIND_MEAS,       make_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00));
    send_frame(KIND_MEAS,       make_frame(16'h0000, 16'hFFFF, 8'h00, 8'h00));
    send_frame(KIND_MEAS,       make_frame(16'h8000, 16'h7FFF, 8'h00, 8'h00));
    send_frame(KIND_MEAS,       make_frame(16'd16852, 16'd65470, 8'h00, 8'h00));
    send_frame(KIND_MEAS,       make_frame(16'd16851, 16'd66, 8'h00, 8'h00));
    send_frame(KIND_MEAS,       make_frame(16'd16848, 16'd65, 8'h00, 8'h00));
    // one word bad: the other still converts
    send_frame(KIND_MEAS,       make_frame(16'h6666, 16'h9999, 8'h01, 8'h00));
    send_frame(KIND_MEAS,       make_frame(16'h6666, 16'h9999, 8'h00, 8'h80));
    send_frame(KIND_MEAS,       make_frame(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
    // spare kind code behaves as a measurement
    send_frame(KIND_SPARE,      make_frame(16'h1234, 16'hABCD, 8'h00, 8'h00));
    send_frame(KIND_SPARE,      make_frame(16'h1234, 16'hABCD, 8'h00, 8'h10));
    // serial read: packed bytes, or all ones on any failure
    send_frame(KIND_SERIAL,     make_frame(16'h0000, 16'h0000, 8'h00, 8'h00));
    send_frame(KIND_SERIAL,     make_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00));
    send_frame(KIND_SERIAL,     make_frame(16'hDEAD, 16'hBEEF, 8'h00, 8'h00));
    send_frame(KIND_SERIAL,     make_frame(16'hDEAD, 16'hBEEF, 8'h04, 8'h00));
    send_frame(KIND_SERIAL,     make_frame(16'hDEAD, 16'hBEEF, 8'h00, 8'h40));
    // soft reset: status only
    send_frame(KIND_SOFT_RESET, make_frame(16'h5A5A, 16'hA5A5, 8'h00, 8'h00));
    send_frame(KIND_SOFT_RESET, make_frame(16'h5A5A, 16'hA5A5, 8'h02, 8'h00));
    send_frame(KIND_SOFT_RESET, 48'hFFFF_FFFF_FFFF);
    send_frame(KIND_MEAS,       48'h0000_0000_0000);
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int per_phase;
    sb           = new;
    rst_ni       = 1'b0;
    src_valid    = 1'b0;
    src_frame    = '0;
    src_kind     = KIND_MEAS;
    snd_idle_pct = 22;
    rcv_idle_pct = 49;
    per_phase    = RAND_FRAMES / 3;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase 1: light source gaps, heavy sink stalls
    run_directed();
    for (int i = 0; i < per_phase; i++) begin
      send_random_frame();
      if (i == per_phase / 2) wait_drained();   // let the pipeline run empty once
    end

    // phase 2: heavy source gaps, light sink stalls
    snd_idle_pct = 49;
    rcv_idle_pct = 22;
    for (int i = 0; i < per_phase; i++) send_random_frame();

    // phase 3: full rate both ways
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    for (int i = 0; i < RAND_FRAMES - 2 * per_phase; i++) send_random_frame();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d frames: %0d measurement, %0d serial read, %0d soft reset",
             sb.n_meas + sb.n_serial + sb.n_reset, sb.n_meas, sb.n_serial, sb.n_reset);
    $display("%0d frames carried a CRC error; %0d result beats checked, %0d bad",
             sb.n_bad_crc, sb.beats_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(8 * 200000);
    $display("timeout with %0d results outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
